>>> src/kis_pkg.sv
package kis_pkg;

  // key and index widths fixed by the word format
  localparam int unsigned KEY_W = 32;
  localparam int unsigned IDX_W = 6;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0]        idx_t;

  // broadcast control from the chain controller to every cell
  typedef struct packed {
    logic ins;      // new key is inserted this cycle
    logic pop;      // head is taken, chain shifts towards cell 0
    key_t new_key;  // key being inserted
    idx_t new_idx;  // arrival position of the key being inserted
  } cell_ctrl_t;

endpackage

>>> src/kis_if.sv
// input channel: one fitness key a word
interface kis_in_if;
  logic          valid;
  logic          ready;
  kis_pkg::key_t fitness_key;
  logic          last_item;

  modport source (output valid, output fitness_key, output last_item, input ready);
  modport sink   (input valid, input fitness_key, input last_item, output ready);
endinterface

// result channel: one ranked entry a word
interface kis_out_if;
  logic          valid;
  logic          ready;
  kis_pkg::key_t sorted_key;
  kis_pkg::idx_t source_index;
  logic          last_result;
  logic          overflowed;

  modport source (output valid, output sorted_key, output source_index,
                  output last_result, output overflowed, input ready);
  modport sink   (input valid, input sorted_key, input source_index,
                  input last_result, input overflowed, output ready);
endinterface

>>> src/key_index_sorter.sv
// channel  dir  handshake         payload
// in_ch    in   valid/ready       fitness_key[31:0] signed, last_item
// out_ch   out  valid/ready       sorted_key[31:0] signed, source_index[5:0],
//                                 last_result, overflowed
//
// load: one key a cycle, inserted in order into a chain of POP_SIZE cells
// drain: after the last word, one result a cycle from the head cell; n results
//   for n held keys, no input taken until the final result has gone
// results come straight from the head cell register; out_ch.ready low holds the chain
// reset: rst_n synchronous, active low; clears fill count, drop flag and drain state
module key_index_sorter #(
  parameter int unsigned POP_SIZE = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  kis_in_if.sink     in_ch,
  kis_out_if.source  out_ch
);

  localparam int unsigned CNT_W = $clog2(POP_SIZE + 1);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                drop_r, drop_nxt;
  logic                drain_r, drain_nxt;
  logic                in_fire, out_fire, has_room;
  kis_pkg::cell_ctrl_t ctrl;

  kis_pkg::key_t key_q [POP_SIZE];
  kis_pkg::idx_t idx_q [POP_SIZE];
  logic          le_q  [POP_SIZE];

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign has_room = count_r < CNT_W'(POP_SIZE);

  // chain control
  assign ctrl.ins     = in_fire && has_room;
  assign ctrl.pop     = out_fire;
  assign ctrl.new_key = in_ch.fitness_key;
  assign ctrl.new_idx = kis_pkg::IDX_W'(count_r);

  // chain of cells, head at cell 0
  for (genvar i = 0; i < POP_SIZE; i++) begin : g_cell
    logic          occ, p_le;
    kis_pkg::key_t p_key, n_key;
    kis_pkg::idx_t p_idx, n_idx;

    assign occ = count_r > CNT_W'(i);

    if (i == 0) begin : g_head
      assign p_le  = 1'b1;
      assign p_key = in_ch.fitness_key;
      assign p_idx = ctrl.new_idx;
    end else begin : g_body
      assign p_le  = le_q[i-1];
      assign p_key = key_q[i-1];
      assign p_idx = idx_q[i-1];
    end

    if (i == POP_SIZE - 1) begin : g_tail
      assign n_key = key_q[i];
      assign n_idx = idx_q[i];
    end else begin : g_inner
      assign n_key = key_q[i+1];
      assign n_idx = idx_q[i+1];
    end

    kis_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (occ),
      .prev_le  (p_le),
      .prev_key (p_key),
      .prev_idx (p_idx),
      .next_key (n_key),
      .next_idx (n_idx),
      .le       (le_q[i]),
      .key_r    (key_q[i]),
      .idx_r    (idx_q[i])
    );
  end

  // handshakes and result word
  assign in_ch.ready         = !drain_r;
  assign out_ch.valid        = drain_r;
  assign out_ch.sorted_key   = key_q[0];
  assign out_ch.source_index = idx_q[0];
  assign out_ch.last_result  = count_r == CNT_W'(1);
  assign out_ch.overflowed   = drop_r;

  // fill count, drop flag and drain state
  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    drain_nxt = drain_r;
    if (in_fire) begin
      if (has_room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        drop_nxt = 1'b1;
      end
      if (in_ch.last_item) begin
        drain_nxt = 1'b1;
      end
    end
    if (out_fire) begin
      count_nxt = count_r - CNT_W'(1);
      if (out_ch.last_result) begin
        drain_nxt = 1'b0;
        drop_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
      drain_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      drain_r <= drain_nxt;
    end
  end

`ifndef SYNTHESIS
  // draining always has something to give
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> count_r != '0)
    else $error("drain with empty chain");

  // fill count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(POP_SIZE))
    else $error("fill count beyond capacity");

  // final result empties the block and clears the drop flag
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_ch.last_result) |=> (count_r == '0 && !drain_r && !drop_r))
    else $error("block not empty after final result");

  // a stored key adds exactly one entry
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not add one entry");
`endif

endmodule

>>> src/kis_cell.sv
module kis_cell (
  input  logic                clk,
  input  kis_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                prev_le,
  input  kis_pkg::key_t       prev_key,
  input  kis_pkg::idx_t       prev_idx,
  input  kis_pkg::key_t       next_key,
  input  kis_pkg::idx_t       next_idx,
  output logic                le,
  output kis_pkg::key_t       key_r,
  output kis_pkg::idx_t       idx_r
);

  kis_pkg::key_t key_nxt;
  kis_pkg::idx_t idx_nxt;

  // held entry stays put when its key is not above the new key (keeps ties stable)
  assign le = occupied && !(ctrl.new_key < key_r);

  // insert: first cell past the smaller-or-equal run takes the new key,
  // the rest shift one place away from the head; pop: shift towards the head
  always_comb begin
    key_nxt = key_r;
    idx_nxt = idx_r;
    if (ctrl.ins && !le) begin
      if (prev_le) begin
        key_nxt = ctrl.new_key;
        idx_nxt = ctrl.new_idx;
      end else begin
        key_nxt = prev_key;
        idx_nxt = prev_idx;
      end
    end else if (ctrl.pop) begin
      key_nxt = next_key;
      idx_nxt = next_idx;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    idx_r <= idx_nxt;
  end

endmodule
